FILE: src/wrcp_pkg.sv
// Shared types, codes and signature constants for the WebP RIFF container parser.
`timescale 1ns / 1ps

package wrcp_pkg;

    localparam int unsigned HDR_BYTES = 12;
    localparam int unsigned MIN_FILE  = 20;
    localparam int unsigned FIELD_BYTES = 10;

    localparam logic [31:0] RIFF_SIG = 32'h52494646;
    localparam logic [31:0] WEBP_SIG = 32'h57454250;
    localparam logic [31:0] TAG_VP8X = 32'h56503858;
    localparam logic [31:0] TAG_VP8  = 32'h56503820;
    localparam logic [31:0] TAG_VP8L = 32'h5650384C;

    localparam logic [7:0] ALPHA_MASK   = 8'h10;
    localparam logic [7:0] ANIM_MASK    = 8'h02;
    localparam logic [7:0] VP8_SYNC0    = 8'h9D;
    localparam logic [7:0] VP8_SYNC1    = 8'h01;
    localparam logic [7:0] VP8_SYNC2    = 8'h2A;
    localparam logic [7:0] VP8L_SIG     = 8'h2F;

    typedef enum logic [2:0] {
        ST_MATCHED     = 3'd0,
        ST_NO_MATCH    = 3'd1,
        ST_NEED_MORE   = 3'd2,
        ST_TRUNC_DATA  = 3'd3,
        ST_TRUNC_CHUNK = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        VAR_NONE = 2'd0,
        VAR_VP8X = 2'd1,
        VAR_VP8  = 2'd2,
        VAR_VP8L = 2'd3
    } variant_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_IDLE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       last_available;
        logic       final_buffer;
    } item_t;

    typedef struct packed {
        logic [24:0] width;
        logic [24:0] height;
        variant_t    variant;
        logic        alpha;
        logic        animated;
    } info_t;

    typedef struct packed {
        status_t     status;
        logic [32:0] match_length;
        logic [24:0] image_width;
        logic [24:0] image_height;
        variant_t    variant;
        logic        has_alpha;
        logic        is_animated;
    } result_t;

    // Byte idx of a four-character signature, first character first.
    function automatic logic [7:0] sig_byte(logic [31:0] sig, logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = sig[31:24];
            2'd1:    r = sig[23:16];
            2'd2:    r = sig[15:8];
            default: r = sig[7:0];
        endcase
        return r;
    endfunction

endpackage

FILE: src/webp_riff_container_parser.sv
// Top level of the WebP RIFF container parser: input register, parse core, result buffer.
`timescale 1ns / 1ps

// Takes one byte of a candidate WebP file per cycle and returns at most one verdict word per
// byte: matched, no match, need more data, truncated payload or truncated chunk, with the
// claimed length and the image information of the last recognized image chunk. A byte is
// registered on acceptance and processed from that input register by the parse core, whose
// per-byte update is a single pass of counter compares and field captures, so the block
// sustains one byte every cycle. A verdict is registered in the result buffer's output or skid
// register before it appears on the output. A two-word result buffer lets input continue while
// a verdict waits to be taken; input stalls only when both buffer words are held.
module webp_riff_container_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_available
    input  logic [1:0]  s_tuser,   // [0] start_of_file, [1] final_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    // [32:0] match_length, [57:33] image_width, [82:58] image_height, [84:83] variant,
    // [85] has_alpha, [86] is_animated, [87] zero
    output logic [87:0] m_tdata,
    output logic [2:0]  m_tuser    // [2:0] status
);

    logic              in_valid_reg;
    wrcp_pkg::item_t   item_reg;
    logic              q_ready;
    logic              step;
    logic              res_valid;
    wrcp_pkg::result_t res;
    wrcp_pkg::result_t out_word;

    assign step     = in_valid_reg && q_ready;
    assign s_tready = !in_valid_reg || q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.data_byte      <= s_tdata;
            item_reg.start_of_file  <= s_tuser[0];
            item_reg.last_available <= s_tlast;
            item_reg.final_buffer   <= s_tuser[1];
        end
    end

    wrcp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wrcp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step && res_valid),
        .push_data  (res),
        .push_ready (q_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_word)
    );

    assign m_tdata = {1'b0, out_word.is_animated, out_word.has_alpha, out_word.variant,
                      out_word.image_height, out_word.image_width, out_word.match_length};
    assign m_tuser = out_word.status;

endmodule

FILE: src/wrcp_out_queue.sv
// Two-entry result buffer: an output register backed by a skid register.
`timescale 1ns / 1ps

module wrcp_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wrcp_pkg::result_t  push_data,
    output logic               push_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output wrcp_pkg::result_t  out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    wrcp_pkg::result_t out_reg;
    wrcp_pkg::result_t skid_reg;
    logic              load_out;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign load_out   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            // A pending skid word moves up first; no push can arrive while it is held.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

FILE: src/wrcp_parse_core.sv
// Parser state and the per-byte update of the header check and chunk walk.
`timescale 1ns / 1ps

module wrcp_parse_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  wrcp_pkg::item_t    item,
    output logic               res_valid,
    output wrcp_pkg::result_t  res
);

    logic [32:0]      byte_count_reg, byte_count_next;
    logic [32:0]      file_length_reg, file_length_next;
    logic             header_ok_reg, header_ok_next;
    wrcp_pkg::phase_t phase_reg, phase_next;
    logic [32:0]      chunk_offset_reg, chunk_offset_next;
    logic [31:0]      chunk_length_reg, chunk_length_next;
    logic [31:0]      chunk_tag_reg, chunk_tag_next;
    logic [7:0]       field_reg [wrcp_pkg::FIELD_BYTES];
    logic [7:0]       field_next [wrcp_pkg::FIELD_BYTES];
    logic             image_found_reg, image_found_next;
    logic             overrun_reg, overrun_next;
    logic             verdict_reg, verdict_next;
    wrcp_pkg::info_t  info_reg, info_next;

    logic [32:0]      pos;
    logic [32:0]      padded;
    logic             do_finish;
    logic             do_begin;
    logic [33:0]      begin_pos;
    logic [7:0]       b;

    function automatic wrcp_pkg::result_t make_result(wrcp_pkg::status_t st, logic [32:0] len,
                                                      logic with_info, wrcp_pkg::info_t inf);
        wrcp_pkg::result_t r;
        r.status       = st;
        r.match_length = len;
        r.image_width  = with_info ? inf.width : 25'd0;
        r.image_height = with_info ? inf.height : 25'd0;
        r.variant      = with_info ? inf.variant : wrcp_pkg::VAR_NONE;
        r.has_alpha    = with_info && (inf.variant == wrcp_pkg::VAR_VP8X) && inf.alpha;
        r.is_animated  = with_info && (inf.variant == wrcp_pkg::VAR_VP8X) && inf.animated;
        return r;
    endfunction

    assign b = item.data_byte;

    always_comb
    begin
        // A start mark restarts the parse from the reset state before this byte.
        if (item.start_of_file)
        begin
            byte_count_next   = '0;
            file_length_next  = '0;
            header_ok_next    = 1'b1;
            phase_next        = wrcp_pkg::PH_HEADER;
            chunk_offset_next = '0;
            chunk_length_next = '0;
            chunk_tag_next    = '0;
            for (int i = 0; i < wrcp_pkg::FIELD_BYTES; i++)
            begin
                field_next[i] = '0;
            end
            image_found_next  = 1'b0;
            overrun_next      = 1'b0;
            verdict_next      = 1'b0;
            info_next         = '0;
        end
        else
        begin
            byte_count_next   = byte_count_reg;
            file_length_next  = file_length_reg;
            header_ok_next    = header_ok_reg;
            phase_next        = phase_reg;
            chunk_offset_next = chunk_offset_reg;
            chunk_length_next = chunk_length_reg;
            chunk_tag_next    = chunk_tag_reg;
            for (int i = 0; i < wrcp_pkg::FIELD_BYTES; i++)
            begin
                field_next[i] = field_reg[i];
            end
            image_found_next  = image_found_reg;
            overrun_next      = overrun_reg;
            verdict_next      = verdict_reg;
            info_next         = info_reg;
        end

        res_valid = 1'b0;
        res       = make_result(wrcp_pkg::ST_NO_MATCH, 33'd0, 1'b0, info_next);
        pos       = byte_count_next;
        padded    = '0;
        do_finish = 1'b0;
        do_begin  = 1'b0;
        begin_pos = '0;

        if (!verdict_next)
        begin
            byte_count_next = pos + 33'd1;

            if (pos < 33'(wrcp_pkg::HDR_BYTES))
            begin
                if (pos < 33'd4)
                begin
                    if (b != wrcp_pkg::sig_byte(wrcp_pkg::RIFF_SIG, pos[1:0]))
                    begin
                        header_ok_next = 1'b0;
                    end
                end
                else if (pos < 33'd8)
                begin
                    case (pos[1:0])
                        2'd0:    file_length_next[7:0]   = b;
                        2'd1:    file_length_next[15:8]  = b;
                        2'd2:    file_length_next[23:16] = b;
                        default: file_length_next[31:24] = b;
                    endcase
                end
                else
                begin
                    if (b != wrcp_pkg::sig_byte(wrcp_pkg::WEBP_SIG, pos[1:0]))
                    begin
                        header_ok_next = 1'b0;
                    end
                end

                if (pos == 33'(wrcp_pkg::HDR_BYTES - 1))
                begin
                    file_length_next = file_length_next + 33'd8;
                    if (!header_ok_next || file_length_next < 33'(wrcp_pkg::MIN_FILE))
                    begin
                        verdict_next = 1'b1;
                        res_valid    = 1'b1;
                        res = make_result(wrcp_pkg::ST_NO_MATCH, 33'd0, 1'b0, info_next);
                    end
                    else
                    begin
                        do_begin  = 1'b1;
                        begin_pos = 34'(wrcp_pkg::HDR_BYTES);
                    end
                end
            end
            else
            begin
                case (phase_next)
                    wrcp_pkg::PH_HEADER:
                    begin
                        if (chunk_offset_next < 33'd4)
                        begin
                            chunk_tag_next = {chunk_tag_next[23:0], b};
                        end
                        else
                        begin
                            case (chunk_offset_next[1:0])
                                2'd0:    chunk_length_next[7:0]   = b;
                                2'd1:    chunk_length_next[15:8]  = b;
                                2'd2:    chunk_length_next[23:16] = b;
                                default: chunk_length_next[31:24] = b;
                            endcase
                        end
                        chunk_offset_next = chunk_offset_next + 33'd1;
                        if (chunk_offset_next == 33'd8)
                        begin
                            padded = {1'b0, chunk_length_next} + {32'd0, chunk_length_next[0]};
                            if ({1'b0, pos} + 34'd1 + {1'b0, padded} > {1'b0, file_length_next})
                            begin
                                overrun_next = 1'b1;
                                phase_next   = wrcp_pkg::PH_IDLE;
                            end
                            else if (padded == 33'd0)
                            begin
                                do_finish = 1'b1;
                                do_begin  = 1'b1;
                                begin_pos = {1'b0, pos} + 34'd1;
                            end
                            else
                            begin
                                phase_next        = wrcp_pkg::PH_DATA;
                                chunk_offset_next = '0;
                            end
                        end
                    end
                    wrcp_pkg::PH_DATA:
                    begin
                        padded = {1'b0, chunk_length_next} + {32'd0, chunk_length_next[0]};
                        if (chunk_offset_next < 33'(wrcp_pkg::FIELD_BYTES))
                        begin
                            field_next[chunk_offset_next[3:0]] = b;
                        end
                        chunk_offset_next = chunk_offset_next + 33'd1;
                        if (chunk_offset_next >= padded)
                        begin
                            do_finish = 1'b1;
                            do_begin  = 1'b1;
                            begin_pos = {1'b0, pos} + 34'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Close out a completed chunk before its registers are cleared.
                if (do_finish)
                begin
                    if (chunk_tag_next == wrcp_pkg::TAG_VP8X || chunk_tag_next == wrcp_pkg::TAG_VP8
                        || chunk_tag_next == wrcp_pkg::TAG_VP8L)
                    begin
                        image_found_next = 1'b1;
                    end
                    if (chunk_tag_next == wrcp_pkg::TAG_VP8X && chunk_length_next >= 32'd10)
                    begin
                        info_next.variant  = wrcp_pkg::VAR_VP8X;
                        info_next.alpha    = (field_next[0] & wrcp_pkg::ALPHA_MASK) != 8'd0;
                        info_next.animated = (field_next[0] & wrcp_pkg::ANIM_MASK) != 8'd0;
                        info_next.width    = {1'b0, field_next[6], field_next[5], field_next[4]}
                                             + 25'd1;
                        info_next.height   = {1'b0, field_next[9], field_next[8], field_next[7]}
                                             + 25'd1;
                    end
                    else if (chunk_tag_next == wrcp_pkg::TAG_VP8 && chunk_length_next >= 32'd10)
                    begin
                        if (field_next[3] == wrcp_pkg::VP8_SYNC0
                            && field_next[4] == wrcp_pkg::VP8_SYNC1
                            && field_next[5] == wrcp_pkg::VP8_SYNC2)
                        begin
                            info_next.variant = wrcp_pkg::VAR_VP8;
                            info_next.width   = {11'd0, field_next[7][5:0], field_next[6]};
                            info_next.height  = {11'd0, field_next[9][5:0], field_next[8]};
                        end
                    end
                    else if (chunk_tag_next == wrcp_pkg::TAG_VP8L && chunk_length_next >= 32'd5)
                    begin
                        if (field_next[0] == wrcp_pkg::VP8L_SIG)
                        begin
                            info_next.variant = wrcp_pkg::VAR_VP8L;
                            info_next.width   = {11'd0, field_next[2][5:0], field_next[1]} + 25'd1;
                            info_next.height  = {11'd0, field_next[4][3:0], field_next[3],
                                                 field_next[2][7:6]} + 25'd1;
                        end
                    end
                end

                if (byte_count_next == file_length_next)
                begin
                    verdict_next = 1'b1;
                    res_valid    = 1'b1;
                    if (overrun_next)
                    begin
                        res = make_result(wrcp_pkg::ST_TRUNC_CHUNK, file_length_next, 1'b1,
                                          info_next);
                    end
                    else if (image_found_next)
                    begin
                        res = make_result(wrcp_pkg::ST_MATCHED, file_length_next, 1'b1,
                                          info_next);
                    end
                    else
                    begin
                        res = make_result(wrcp_pkg::ST_NO_MATCH, 33'd0, 1'b0, info_next);
                    end
                end
            end

            if (do_begin)
            begin
                chunk_offset_next = '0;
                chunk_tag_next    = '0;
                chunk_length_next = '0;
                for (int i = 0; i < wrcp_pkg::FIELD_BYTES; i++)
                begin
                    field_next[i] = '0;
                end
                // Fewer than eight bytes before the end of file cannot hold a chunk header.
                phase_next = (begin_pos + 34'd8 <= {1'b0, file_length_next}) ?
                             wrcp_pkg::PH_HEADER : wrcp_pkg::PH_IDLE;
            end

            if (!res_valid && item.last_available)
            begin
                res_valid = 1'b1;
                if (item.final_buffer)
                begin
                    verdict_next = 1'b1;
                    if (byte_count_next < 33'(wrcp_pkg::HDR_BYTES))
                    begin
                        res = make_result(wrcp_pkg::ST_NO_MATCH, 33'd0, 1'b0, info_next);
                    end
                    else
                    begin
                        res = make_result(wrcp_pkg::ST_TRUNC_DATA, byte_count_next, 1'b0,
                                          info_next);
                    end
                end
                else
                begin
                    res = make_result(wrcp_pkg::ST_NEED_MORE, 33'd0, 1'b0, info_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            file_length_reg  <= '0;
            header_ok_reg    <= 1'b1;
            phase_reg        <= wrcp_pkg::PH_HEADER;
            chunk_offset_reg <= '0;
            chunk_length_reg <= '0;
            chunk_tag_reg    <= '0;
            for (int i = 0; i < wrcp_pkg::FIELD_BYTES; i++)
            begin
                field_reg[i] <= '0;
            end
            image_found_reg  <= 1'b0;
            overrun_reg      <= 1'b0;
            verdict_reg      <= 1'b0;
            info_reg         <= '0;
        end
        else if (step)
        begin
            byte_count_reg   <= byte_count_next;
            file_length_reg  <= file_length_next;
            header_ok_reg    <= header_ok_next;
            phase_reg        <= phase_next;
            chunk_offset_reg <= chunk_offset_next;
            chunk_length_reg <= chunk_length_next;
            chunk_tag_reg    <= chunk_tag_next;
            for (int i = 0; i < wrcp_pkg::FIELD_BYTES; i++)
            begin
                field_reg[i] <= field_next[i];
            end
            image_found_reg  <= image_found_next;
            overrun_reg      <= overrun_next;
            verdict_reg      <= verdict_next;
            info_reg         <= info_next;
        end
    end

endmodule
